@@ rtl/core/static_linked_list_engine_defines.svh @@
// Assertion macros used by the linked list engine checker file.
// No dependencies; include by bare file name.
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define SLLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slle assertion failed: %m");

// next-cycle implication
`define SLLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slle assertion failed: %m");

`endif

@@ rtl/core/slle_pkg.sv @@
// Package for the static linked list engine: codes, widths and the microcode ROM.
// No dependencies; used by the top level and its checker.
`default_nettype none

package slle_pkg;

  localparam int unsigned NODES_DEFAULT = 16;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;
  localparam int SLOT_O_W = 4;
  localparam int LEN_W    = 4;
  localparam int UPC_W    = 5;

  localparam logic [KIND_W-1:0] K_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] K_APPEND  = 3'd1;
  localparam logic [KIND_W-1:0] K_DELETE  = 3'd2;
  localparam logic [KIND_W-1:0] K_SEARCH  = 3'd3;
  localparam logic [KIND_W-1:0] K_REPLACE = 3'd4;
  localparam logic [KIND_W-1:0] K_CLEAR   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_POS = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t S_INS      = 5'd0;
  localparam upc_t S_INS_FULL = 5'd1;
  localparam upc_t S_WALK_I   = 5'd2;
  localparam upc_t S_ALLOC_A  = 5'd3;
  localparam upc_t S_ALLOC_B  = 5'd4;
  localparam upc_t S_ALLOC_C  = 5'd5;
  localparam upc_t S_DEL      = 5'd6;
  localparam upc_t S_WALK_D   = 5'd7;
  localparam upc_t S_UNLINK   = 5'd8;
  localparam upc_t S_RELEASE  = 5'd9;
  localparam upc_t S_FIND     = 5'd10;
  localparam upc_t S_FEND     = 5'd11;
  localparam upc_t S_CLEAR    = 5'd12;
  localparam upc_t S_NOP      = 5'd13;
  localparam upc_t S_BADPOS   = 5'd14;
  localparam upc_t S_FULL     = 5'd15;
  localparam upc_t S_MISSING  = 5'd16;
  localparam upc_t S_DONE     = 5'd17;

  typedef enum logic [2:0] {
    C_NEVER,
    C_BAD_INS,
    C_FULL,
    C_BAD_DEL,
    C_AT_POS,
    C_FIND_END,
    C_MISS,
    C_OUT_HELD
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_ADV,
    A_RD_FREE,
    A_ALLOC,
    A_LINK_NEW,
    A_UNLINK,
    A_RELEASE,
    A_HIT,
    A_CLEAR,
    A_ST_BAD,
    A_ST_FULL,
    A_ST_MISS,
    A_EMIT
  } act_t;

  // cond true: jump to target, no action; else act, then loop, finish or step on
  typedef struct packed {
    cond_t cond;
    upc_t  target;
    logic  loop;
    logic  fin;
    act_t  act;
  } ucode_t;

  function automatic ucode_t ucode(upc_t pc);
    ucode_t w;
    w = '{C_NEVER, S_DONE, 1'b0, 1'b1, A_NONE};
    unique case (pc)
      S_INS:      w = '{C_BAD_INS,  S_BADPOS,  1'b0, 1'b0, A_NONE};
      S_INS_FULL: w = '{C_FULL,     S_FULL,    1'b0, 1'b0, A_NONE};
      S_WALK_I:   w = '{C_AT_POS,   S_ALLOC_A, 1'b1, 1'b0, A_ADV};
      S_ALLOC_A:  w = '{C_NEVER,    S_DONE,    1'b0, 1'b0, A_RD_FREE};
      S_ALLOC_B:  w = '{C_NEVER,    S_DONE,    1'b0, 1'b0, A_ALLOC};
      S_ALLOC_C:  w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_LINK_NEW};
      S_DEL:      w = '{C_BAD_DEL,  S_BADPOS,  1'b0, 1'b0, A_NONE};
      S_WALK_D:   w = '{C_AT_POS,   S_UNLINK,  1'b1, 1'b0, A_ADV};
      S_UNLINK:   w = '{C_NEVER,    S_DONE,    1'b0, 1'b0, A_UNLINK};
      S_RELEASE:  w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_RELEASE};
      S_FIND:     w = '{C_FIND_END, S_FEND,    1'b1, 1'b0, A_ADV};
      S_FEND:     w = '{C_MISS,     S_MISSING, 1'b0, 1'b1, A_HIT};
      S_CLEAR:    w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_CLEAR};
      S_NOP:      w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_NONE};
      S_BADPOS:   w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_ST_BAD};
      S_FULL:     w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_ST_FULL};
      S_MISSING:  w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_ST_MISS};
      S_DONE:     w = '{C_OUT_HELD, S_DONE,    1'b0, 1'b1, A_EMIT};
      default:    w = '{C_NEVER,    S_DONE,    1'b0, 1'b1, A_NONE};
    endcase
    return w;
  endfunction

  function automatic upc_t entry_of(logic [KIND_W-1:0] k);
    upc_t pc;
    pc = S_NOP;
    unique case (k)
      K_INSERT, K_APPEND:  pc = S_INS;
      K_DELETE:            pc = S_DEL;
      K_SEARCH, K_REPLACE: pc = S_FIND;
      K_CLEAR:             pc = S_CLEAR;
      default:             pc = S_NOP;
    endcase
    return pc;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/static_linked_list_engine.sv @@
// Static linked list engine: microcoded sequencer over link and payload memories.
// Depends on slle_pkg.
//
//   channel  valid      stall      fields
//   cmd      cmd_valid  cmd_stall  kind, position, value, new_value
//   res      res_valid  res_stall  status, slot, length
//
// One command at a time, accepted while idle; then one microcode step a cycle.
// Insert and delete walk to the given position, search and replace at most the whole
// list; the walk costs one link-memory read per node visited.
// Clear and reset take effect at once: a fill mark stands in for untouched links.
// A held result stalls the sequencer only at its final step.
`default_nettype none

module static_linked_list_engine #(
  parameter int unsigned NODES = slle_pkg::NODES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic        [slle_pkg::KIND_W-1:0] kind,
  input  logic        [slle_pkg::POS_W-1:0]  position,
  input  logic signed [slle_pkg::VAL_W-1:0]  value,
  input  logic signed [slle_pkg::VAL_W-1:0]  new_value,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic        [slle_pkg::ST_W-1:0]   status,
  output logic        [slle_pkg::SLOT_O_W-1:0] slot,
  output logic        [slle_pkg::LEN_W-1:0]  length
);
  import slle_pkg::*;

  localparam int SW = $clog2(NODES);
  localparam int PW = (SW > POS_W) ? SW : POS_W;
  localparam int HW = SW + 1;
  localparam logic [SW-1:0] LAST_SLOT  = SW'(NODES - 1);
  localparam logic [SW-1:0] LIST_HEAD  = SW'(1);
  localparam logic [SW-1:0] FIRST_FREE = SW'(2);

  logic [SW-1:0]    nl_mem [NODES];
  logic [VAL_W-1:0] pl_mem [NODES];

  logic             busy;
  upc_t             upc;
  logic [KIND_W-1:0] kind_r;
  logic [PW-1:0]    pos_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] nval_r;
  logic [SW-1:0]    prev;
  logic [SW-1:0]    cur;
  logic [SW-1:0]    idx;
  logic [SW-1:0]    node_slot;
  logic [ST_W-1:0]  code;
  logic [SW-1:0]    count;
  logic [SW-1:0]    free_head;
  logic [SW-1:0]    first_node;
  logic [HW-1:0]    hwm;
  logic [SW-1:0]    raddr;
  logic [SW-1:0]    nl_q;
  logic [VAL_W-1:0] pl_q;

  ucode_t           ctrl;
  logic             cond_hit;
  act_t             act_now;
  logic             accept;
  logic [SW-1:0]    lk;
  logic             rd_en;
  logic [SW-1:0]    rd_addr;
  logic             nl_we;
  logic [SW-1:0]    nl_waddr;
  logic [SW-1:0]    nl_wdata;
  logic             pl_we;
  logic [SW-1:0]    pl_waddr;
  logic [VAL_W-1:0] pl_wdata;
  logic [PW-1:0]    slot_ext;
  logic [PW-1:0]    count_ext;

  assign cmd_stall = busy;
  assign accept    = cmd_valid && !cmd_stall;
  assign ctrl      = ucode(upc);
  assign count_ext = PW'(count);
  assign slot_ext  = PW'(node_slot);

  assign lk = (HW'(raddr) >= hwm) ? ((raddr == LAST_SLOT) ? '0 : raddr + 1'b1) : nl_q;

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_BAD_INS:  cond_hit = pos_r > count_ext;
      C_FULL:     cond_hit = free_head == '0;
      C_BAD_DEL:  cond_hit = pos_r >= count_ext;
      C_AT_POS:   cond_hit = PW'(idx) == pos_r;
      C_FIND_END: cond_hit = (idx == count) || (pl_q == val_r);
      C_MISS:     cond_hit = idx == count;
      C_OUT_HELD: cond_hit = res_valid && res_stall;
      default:    cond_hit = 1'b0;
    endcase
  end

  assign act_now = (busy && !cond_hit) ? ctrl.act : A_NONE;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    nl_we    = 1'b0;
    nl_waddr = '0;
    nl_wdata = '0;
    pl_we    = 1'b0;
    pl_waddr = '0;
    pl_wdata = '0;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = first_node;
    end
    unique case (act_now)
      A_ADV: begin
        rd_en   = 1'b1;
        rd_addr = lk;
      end
      A_RD_FREE: begin
        rd_en   = 1'b1;
        rd_addr = free_head;
      end
      A_ALLOC: begin
        nl_we    = 1'b1;
        nl_waddr = free_head;
        nl_wdata = cur;
        pl_we    = 1'b1;
        pl_waddr = free_head;
        pl_wdata = val_r;
      end
      A_LINK_NEW: begin
        nl_we    = prev != LIST_HEAD;
        nl_waddr = prev;
        nl_wdata = node_slot;
      end
      A_UNLINK: begin
        nl_we    = prev != LIST_HEAD;
        nl_waddr = prev;
        nl_wdata = lk;
      end
      A_RELEASE: begin
        nl_we    = 1'b1;
        nl_waddr = cur;
        nl_wdata = free_head;
      end
      A_HIT: begin
        pl_we    = kind_r == K_REPLACE;
        pl_waddr = cur;
        pl_wdata = nval_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_waddr] <= nl_wdata;
    end
    if (rd_en) begin
      nl_q  <= nl_mem[rd_addr];
      raddr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[pl_waddr] <= pl_wdata;
    end
    if (rd_en) begin
      pl_q <= pl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      upc        <= S_NOP;
      res_valid  <= 1'b0;
      count      <= '0;
      free_head  <= FIRST_FREE;
      first_node <= '0;
      hwm        <= HW'(2);
    end else begin
      if (accept) begin
        busy <= 1'b1;
        upc  <= entry_of(kind);
      end else if (busy) begin
        if (cond_hit) begin
          upc <= ctrl.target;
        end else if (ctrl.loop) begin
          upc <= upc;
        end else if (ctrl.fin) begin
          upc <= S_DONE;
        end else begin
          upc <= upc + 1'b1;
        end
      end

      if (act_now == A_EMIT) begin
        res_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (act_now)
        A_ALLOC: begin
          free_head <= lk;
          if (HW'(free_head) >= hwm) begin
            hwm <= HW'(free_head) + HW'(1);
          end
        end
        A_LINK_NEW: begin
          if (prev == LIST_HEAD) begin
            first_node <= node_slot;
          end
          count <= count + 1'b1;
        end
        A_UNLINK: begin
          if (prev == LIST_HEAD) begin
            first_node <= lk;
          end
        end
        A_RELEASE: begin
          free_head <= cur;
          count     <= count - 1'b1;
        end
        A_CLEAR: begin
          free_head  <= FIRST_FREE;
          first_node <= '0;
          count      <= '0;
          hwm        <= HW'(2);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind;
      pos_r     <= (kind == K_APPEND) ? count_ext : PW'(position);
      val_r     <= value;
      nval_r    <= new_value;
      prev      <= LIST_HEAD;
      cur       <= first_node;
      idx       <= '0;
      node_slot <= '0;
      code      <= ST_OK;
    end
    unique case (act_now)
      A_ADV: begin
        prev <= cur;
        cur  <= lk;
        idx  <= idx + 1'b1;
      end
      A_ALLOC:   node_slot <= free_head;
      A_RELEASE: node_slot <= cur;
      A_HIT:     node_slot <= cur;
      A_ST_BAD:  code <= ST_BAD_POS;
      A_ST_FULL: code <= ST_FULL;
      A_ST_MISS: code <= ST_MISSING;
      A_EMIT: begin
        status <= code;
        slot   <= slot_ext[SLOT_O_W-1:0];
        length <= count_ext[LEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/slle_checker.sv @@
// Port-level checker for the static linked list engine, bound to the top level.
// Depends on slle_pkg and static_linked_list_engine_defines.svh.
`default_nettype none
`include "static_linked_list_engine_defines.svh"

module slle_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_stall,
  input logic                            res_valid,
  input logic                            res_stall,
  input logic [slle_pkg::ST_W-1:0]       status,
  input logic [slle_pkg::SLOT_O_W-1:0]   slot,
  input logic [slle_pkg::LEN_W-1:0]      length
);
  import slle_pkg::*;

  // a failed transaction never names a slot
  `SLLE_ASSERT_NOW(a_fail_no_slot, res_valid && (status != ST_OK), slot == '0)
  // an accepted command raises the registered busy stall
  `SLLE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall)
  // a result appears only as the end of a command in progress
  `SLLE_ASSERT_NOW(a_result_from_cmd, $rose(res_valid), $past(cmd_stall))
  // hold a stalled result
  `SLLE_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(status) && $stable(slot) && $stable(length))

endmodule

bind static_linked_list_engine slle_checker u_slle_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for static_linked_list_engine: a directed command table,
// then random list traffic; results are compared against a behavioural list model
// or, for fixed directed rows, a stored expectation. Depends on slle_pkg and the engine RTL.
module testbench;
  import slle_pkg::*;

  localparam int STORE_SLOTS  = NODES_DEFAULT;
  localparam int DIRECTED_N   = 28;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_ITEMS  = 120;

  typedef struct packed {
    logic [ST_W-1:0]     st;
    logic [SLOT_O_W-1:0] sl;
    logic [LEN_W-1:0]    len;
  } outcome_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic [VAL_W-1:0]  nval;
    logic              fixed;
    outcome_t          want;
  } cmd_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cmd_valid;
  logic                     cmd_stall;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;
  logic signed [VAL_W-1:0]  new_value;
  logic                     res_valid;
  logic                     res_stall;
  logic [ST_W-1:0]          status;
  logic [SLOT_O_W-1:0]      slot;
  logic [LEN_W-1:0]         length;

  logic       quiet;
  int         stall_left;
  outcome_t   expected_results[$];
  outcome_t   front_result;
  int         results_seen;
  int         mismatches;
  int         unexpected;
  int         kind_tally[8];
  int         status_tally[4];

  logic [3:0]       node_next[STORE_SLOTS];
  logic [VAL_W-1:0] node_val[STORE_SLOTS];
  logic [3:0]       free_top;
  logic [3:0]       list_first;
  logic [3:0]       list_len;

  logic [VAL_W-1:0] value_pool[8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
                                      32'h0000_002A, 32'h55AA_55AA};

  cmd_row_t directed_rows[DIRECTED_N] = '{
    '{K_SEARCH,  4'd0,  32'h0000_0000, 32'h0, 1'b1, '{ST_MISSING, 4'd0, 4'd0}},
    '{K_DELETE,  4'd0,  32'h0000_0000, 32'h0, 1'b1, '{ST_BAD_POS, 4'd0, 4'd0}},
    '{K_INSERT,  4'd1,  32'h0000_0009, 32'h0, 1'b1, '{ST_BAD_POS, 4'd0, 4'd0}},
    '{K_REPLACE, 4'd0,  32'h0000_0009, 32'h1, 1'b1, '{ST_MISSING, 4'd0, 4'd0}},
    '{K_INSERT,  4'd0,  32'h7FFF_FFFF, 32'h0, 1'b1, '{ST_OK, 4'd2, 4'd1}},
    '{K_APPEND,  4'd0,  32'h8000_0000, 32'h0, 1'b1, '{ST_OK, 4'd3, 4'd2}},
    '{K_INSERT,  4'd1,  32'hFFFF_FFFF, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_SEARCH,  4'd0,  32'hFFFF_FFFF, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_REPLACE, 4'd0,  32'h8000_0000, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_DELETE,  4'd0,  32'h0000_0000, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_APPEND,  4'd0,  32'h0000_0005, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_DELETE,  4'd3,  32'h0000_0000, 32'h0, 1'b1, '{ST_BAD_POS, 4'd0, 4'd3}},
    '{K_INSERT,  4'd0,  32'h0000_0001, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd4,  32'h0000_0002, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd2,  32'h0000_0003, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_APPEND,  4'd0,  32'h0000_0004, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd7,  32'h8000_0001, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd8,  32'h7FFF_FFFE, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd9,  32'hA5A5_A5A5, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd1,  32'h5A5A_5A5A, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_APPEND,  4'd0,  32'hDEAD_BEEF, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd12, 32'h0F0F_0F0F, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_INSERT,  4'd13, 32'hF0F0_F0F0, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_APPEND,  4'd0,  32'h0000_0077, 32'h0, 1'b1, '{ST_FULL, 4'd0, 4'd14}},
    '{K_INSERT,  4'd14, 32'h0000_0078, 32'h0, 1'b1, '{ST_FULL, 4'd0, 4'd14}},
    '{K_DELETE,  4'd13, 32'h0000_0000, 32'h0, 1'b0, '{ST_OK, 4'd0, 4'd0}},
    '{K_CLEAR,   4'd0,  32'h0000_0000, 32'h0, 1'b1, '{ST_OK, 4'd0, 4'd0}},
    '{K_SEARCH,  4'd0,  32'h0000_0000, 32'h0, 1'b1, '{ST_MISSING, 4'd0, 4'd0}}
  };

  static_linked_list_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .new_value (new_value),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .slot      (slot),
    .length    (length)
  );

  always #5 clk = ~clk;

  function automatic void list_reset();
    for (int i = 0; i < STORE_SLOTS; i++) begin
      node_next[i] = (i + 1 < STORE_SLOTS) ? 4'(i + 1) : 4'd0;
      node_val[i]  = '0;
    end
    free_top   = 4'd2;
    list_first = 4'd0;
    list_len   = 4'd0;
  endfunction

  function automatic logic [3:0] link_of(logic [3:0] node);
    if (node == 4'd1) return list_first;
    if (node == 4'd0) return free_top;
    return node_next[node];
  endfunction

  function automatic void set_link(logic [3:0] node, logic [3:0] target);
    if (node == 4'd1) list_first = target;
    else if (node == 4'd0) free_top = target;
    else node_next[node] = target;
  endfunction

  function automatic logic [3:0] walk_to(logic [3:0] steps, output logic [3:0] prev);
    logic [3:0] cur;
    prev = 4'd1;
    cur  = list_first;
    for (int i = 0; i < steps; i++) begin
      prev = cur;
      cur  = link_of(cur);
    end
    return cur;
  endfunction

  function automatic outcome_t apply_command(logic [KIND_W-1:0] k, logic [POS_W-1:0] pos,
                                             logic [VAL_W-1:0] val, logic [VAL_W-1:0] nval);
    outcome_t   o;
    logic [3:0] p;
    logic [3:0] prev;
    logic [3:0] cur;
    logic [3:0] s;
    o = '{ST_OK, 4'd0, 4'd0};
    p = pos;
    case (k)
      K_INSERT, K_APPEND: begin
        if (k == K_APPEND) p = list_len;
        if (p > list_len) begin
          o.st = ST_BAD_POS;
        end else if (free_top == 4'd0) begin
          o.st = ST_FULL;
        end else begin
          cur          = walk_to(p, prev);
          s            = free_top;
          free_top     = node_next[s];
          node_next[s] = cur;
          node_val[s]  = val;
          set_link(prev, s);
          list_len++;
          o.sl = s;
        end
      end
      K_DELETE: begin
        if (p >= list_len) begin
          o.st = ST_BAD_POS;
        end else begin
          cur = walk_to(p, prev);
          if (cur >= 4'd2) begin
            set_link(prev, node_next[cur]);
            node_next[cur] = free_top;
            free_top       = cur;
            list_len--;
            o.sl = cur;
          end else begin
            o.st = ST_BAD_POS;
          end
        end
      end
      K_SEARCH, K_REPLACE: begin
        s   = 4'd0;
        cur = list_first;
        for (int i = 0; i < list_len; i++) begin
          if (s == 4'd0 && cur >= 4'd2 && node_val[cur] == val) s = cur;
          cur = link_of(cur);
        end
        if (s == 4'd0) begin
          o.st = ST_MISSING;
        end else begin
          if (k == K_REPLACE) node_val[s] = nval;
          o.sl = s;
        end
      end
      K_CLEAR: list_reset();
      default: ;
    endcase
    o.len = list_len;
    return o;
  endfunction

  task automatic send_command(input cmd_row_t r);
    outcome_t o;
    kind      <= r.kind;
    position  <= r.pos;
    value     <= r.val;
    new_value <= r.nval;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    o = apply_command(r.kind, r.pos, r.val, r.nval);
    expected_results.push_back(r.fixed ? r.want : o);
    kind_tally[r.kind]++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // receiver backpressure in short bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      res_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        unexpected++;
        $display("unexpected result: status %0d slot %0d length %0d", status, slot, length);
      end else begin
        front_result = expected_results.pop_front();
        status_tally[front_result.st]++;
        if (status !== front_result.st || slot !== front_result.sl ||
            length !== front_result.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: status %0d/%0d slot %0d/%0d length %0d/%0d (exp/act)",
                     results_seen, front_result.st, status, front_result.sl, slot,
                     front_result.len, length);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    cmd_row_t   r;
    int         pick;
    int         t_clear;
    int         t_ins;
    int         t_app;
    logic       grow;
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    kind         = K_INSERT;
    position     = '0;
    value        = '0;
    new_value    = '0;
    quiet        = 1'b0;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    list_reset();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++) send_command(directed_rows[i]);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      if (n == RANDOM_ITEMS / 2) drain_results();
      // alternate phases that fill and empty the store
      grow    = ((n / 120) % 2) == 0;
      t_clear = grow ? 1 : 3;
      t_ins   = grow ? 60 : 38;
      t_app   = grow ? 80 : 46;
      pick    = $urandom_range(0, 99);
      if (pick < t_clear) r.kind = K_CLEAR;
      else if (pick < 16) r.kind = K_SEARCH;
      else if (pick < 26) r.kind = K_REPLACE;
      else if (pick < t_ins) r.kind = K_INSERT;
      else if (pick < t_app) r.kind = K_APPEND;
      else r.kind = K_DELETE;
      if ($urandom_range(0, 9) < 8) r.pos = POS_W'($urandom_range(0, list_len));
      else r.pos = POS_W'($urandom_range(0, 14));
      r.val   = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)] : $urandom;
      r.nval  = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
      r.fixed = 1'b0;
      r.want  = '0;
      send_command(r);
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("Ran %0d inserts, %0d appends, %0d deletes, %0d searches, %0d replaces, %0d clears.",
             kind_tally[K_INSERT], kind_tally[K_APPEND], kind_tally[K_DELETE],
             kind_tally[K_SEARCH], kind_tally[K_REPLACE], kind_tally[K_CLEAR]);
    $display("Checked %0d results: %0d ok, %0d store full, %0d bad position, %0d not found.",
             results_seen, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_BAD_POS], status_tally[ST_MISSING]);
    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/slle_pkg.sv
rtl/core/static_linked_list_engine.sv
rtl/core/slle_checker.sv
sim/testbench.sv
